FILE: rtl/padr_pkg.sv
`default_nettype none

package padr_pkg;

  localparam int DspBlocks = 8;
  localparam int BlkW      = (DspBlocks > 1) ? $clog2(DspBlocks) : 1;

  typedef enum logic [3:0] {
    RG_UNMAPPED = 4'd0,
    RG_IO       = 4'd1,
    RG_ARM9RAM  = 4'd2,
    RG_VRAM     = 4'd3,
    RG_EXTVRAM  = 4'd4,
    RG_AXIWRAM  = 4'd5,
    RG_FCRAM    = 4'd6,
    RG_EXTFCRAM = 4'd7,
    RG_ROM11    = 4'd8,
    RG_ROM9     = 4'd9,
    RG_DSPWRAM  = 4'd10,
    RG_OVERLAY  = 4'd11
  } region_t;

  typedef enum logic [2:0] {
    CFG_CODE_MAP  = 3'd0,
    CFG_DATA_MAP  = 3'd1,
    CFG_ARM9_EXT  = 3'd2,
    CFG_EXT_VRAM  = 3'd3,
    CFG_FCRAM_EXT = 3'd4,
    CFG_BOOT_OVL  = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic [63:0] code_map;
    logic [63:0] data_map;
    logic        arm9_ram_ext;
    logic        ext_vram_en;
    logic        fcram_ext;
    logic        boot_ovl_en;
  } cfg_t;

  typedef struct packed {
    logic dsp;      // DSP WRAM window
    logic ram9;
    logic vram;
    logic extvram;
    logic axi;
    logic fcram;
    logic extfcram;
    logic io;
    logic low;      // below 0x20000
    logic high;     // at or above 0xFFFF0000
    logic top8k;    // at or above 0xFFFFE000
    logic page0;    // first 4KB page of a 64KB block
  } flags_t;

  typedef struct packed {
    logic [31:0]          address;
    logic                 arm9;
    logic                 wr;
    flags_t               flags;
    logic [DspBlocks-1:0] hits;
  } s1_t;

  typedef struct packed {
    logic [26:0]     address;
    region_t         region;
    logic [BlkW-1:0] blk;
  } s2_t;

endpackage

`default_nettype wire

FILE: rtl/padr_cfg.sv
`default_nettype none

module padr_cfg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr_en,
  input  wire logic [2:0]    index,
  input  wire logic [63:0]   data,
  output padr_pkg::cfg_t     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (padr_pkg::cfg_index_t'(index))
        padr_pkg::CFG_CODE_MAP:  cfg.code_map     <= data;
        padr_pkg::CFG_DATA_MAP:  cfg.data_map     <= data;
        padr_pkg::CFG_ARM9_EXT:  cfg.arm9_ram_ext <= data[0];
        padr_pkg::CFG_EXT_VRAM:  cfg.ext_vram_en  <= data[0];
        padr_pkg::CFG_FCRAM_EXT: cfg.fcram_ext    <= data[0];
        padr_pkg::CFG_BOOT_OVL:  cfg.boot_ovl_en  <= data[0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/padr_match.sv
`default_nettype none

// Stage 1: range compares and DSP block slot match.
module padr_match (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire logic        in_vld,
  input  wire logic [31:0] address,
  input  wire logic        arm9,
  input  wire logic        wr,
  input  wire padr_pkg::cfg_t cfg,
  output logic             out_vld,
  output padr_pkg::s1_t    out
);

  padr_pkg::s1_t s1_next;
  logic [63:0]   map;

  always_comb begin
    s1_next.address = address;
    s1_next.arm9    = arm9;
    s1_next.wr      = wr;

    s1_next.flags.dsp      = (address[31:19] == 13'h3FE);
    s1_next.flags.ram9     = arm9 && ((address[31:20] == 12'h080) ||
                             (cfg.arm9_ram_ext && address[31:19] == 13'h102));
    s1_next.flags.vram     = (address[31:23] == 9'h030) && (address[22:21] != 2'b11);
    s1_next.flags.extvram  = !arm9 && cfg.ext_vram_en && (address[31:22] == 10'h07C);
    s1_next.flags.axi      = (address[31:19] == 13'h3FF);
    s1_next.flags.fcram    = (address[31:27] == 5'b00100);
    s1_next.flags.extfcram = cfg.fcram_ext && (address[31:27] == 5'b00101);
    s1_next.flags.io       = (address[31:27] == 5'b00010);
    s1_next.flags.low      = (address[31:17] == '0);
    s1_next.flags.high     = (address[31:16] == '1);
    s1_next.flags.top8k    = (address[31:13] == '1);
    s1_next.flags.page0    = (address[15:12] == '0);

    // bit 18 picks the data half of the window
    map = address[18] ? cfg.data_map : cfg.code_map;
    for (int i = 0; i < padr_pkg::DspBlocks; i++) begin
      s1_next.hits[i] = map[8*i+7] && (map[8*i+2 +: 3] == address[17:15]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out <= s1_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/padr_resolve.sv
`default_nettype none

// Stage 2: lowest-block pick, region priority and miss classing.
module padr_resolve (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      en,
  input  wire logic      in_vld,
  input  wire padr_pkg::s1_t in,
  input  wire logic      boot_ovl_en,
  output logic           out_vld,
  output padr_pkg::s2_t  out
);

  padr_pkg::s2_t     s2_next;
  logic              hit;
  logic              boot11;
  padr_pkg::flags_t  f;

  always_comb begin
    f   = in.flags;
    hit = |in.hits;
    s2_next.address = in.address[26:0];
    s2_next.blk     = '0;
    for (int i = padr_pkg::DspBlocks - 1; i >= 0; i--) begin
      if (in.hits[i]) s2_next.blk = padr_pkg::BlkW'(i);
    end

    boot11 = !in.arm9 && (f.low || f.high);

    if (f.dsp) begin
      s2_next.region = hit ? padr_pkg::RG_DSPWRAM : padr_pkg::RG_UNMAPPED;
    end else if (f.ram9) begin
      s2_next.region = padr_pkg::RG_ARM9RAM;
    end else if (f.vram) begin
      s2_next.region = padr_pkg::RG_VRAM;
    end else if (f.extvram) begin
      s2_next.region = padr_pkg::RG_EXTVRAM;
    end else if (f.axi) begin
      s2_next.region = padr_pkg::RG_AXIWRAM;
    end else if (f.fcram) begin
      s2_next.region = padr_pkg::RG_FCRAM;
    end else if (f.extfcram) begin
      s2_next.region = padr_pkg::RG_EXTFCRAM;
    end else if (!in.wr && boot11 && (!f.page0 || !boot_ovl_en)) begin
      s2_next.region = padr_pkg::RG_ROM11;
    end else if (!in.wr && in.arm9 && f.high) begin
      s2_next.region = padr_pkg::RG_ROM9;
    end else if (in.wr && !in.arm9 && f.top8k) begin
      s2_next.region = padr_pkg::RG_ROM11;
    end else if (f.io) begin
      s2_next.region = padr_pkg::RG_IO;
    end else if (!in.wr && boot11) begin
      s2_next.region = padr_pkg::RG_OVERLAY;
    end else begin
      s2_next.region = padr_pkg::RG_UNMAPPED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out <= s2_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/physical_address_region_decoder_core.sv
// One item per cycle while the output is not stalled.
// Stages: range/slot match, region resolve, offset form + output register.
// A stall on the output holds all three stages together (one shared enable).
// Reset (rst, synchronous): clears stage valid bits and all config registers.
`default_nettype none

module physical_address_region_decoder_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] address,
  input  wire logic        requester_arm9,
  input  wire logic        func,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       region,
  output logic [26:0]      offset,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  padr_pkg::cfg_t cfg;
  padr_pkg::s1_t  s1;
  padr_pkg::s2_t  s2;
  logic           s1_vld;
  logic           s2_vld;
  logic           en;
  logic [26:0]    offset_next;

  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  padr_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .wr_en (cfg_valid && cfg_ready),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  padr_match u_match (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (in_valid),
    .address (address),
    .arm9    (requester_arm9),
    .wr      (func),
    .cfg     (cfg),
    .out_vld (s1_vld),
    .out     (s1)
  );

  padr_resolve u_resolve (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_vld      (s1_vld),
    .in          (s1),
    .boot_ovl_en (cfg.boot_ovl_en),
    .out_vld     (s2_vld),
    .out         (s2)
  );

  always_comb begin
    case (s2.region)
      // data half keeps bit 18, block index replaces the slot bits
      padr_pkg::RG_DSPWRAM:  offset_next = 27'({s2.address[18], 3'(s2.blk),
                                                s2.address[14:0]});
      padr_pkg::RG_ARM9RAM:  offset_next = 27'(s2.address[20:0]);
      padr_pkg::RG_VRAM:     offset_next = 27'(s2.address[22:0]);
      padr_pkg::RG_EXTVRAM:  offset_next = 27'(s2.address[21:0]);
      padr_pkg::RG_AXIWRAM:  offset_next = 27'(s2.address[18:0]);
      padr_pkg::RG_FCRAM,
      padr_pkg::RG_EXTFCRAM: offset_next = s2.address;
      padr_pkg::RG_ROM11,
      padr_pkg::RG_ROM9:     offset_next = 27'(s2.address[15:0]);
      default:               offset_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      region <= s2.region;
      offset <= offset_next;
    end
  end

`ifndef SYNTHESIS
  a_zero_offset: assert property (@(posedge clk) disable iff (rst)
    out_valid && (region == padr_pkg::RG_UNMAPPED || region == padr_pkg::RG_IO ||
                  region == padr_pkg::RG_OVERLAY) |-> offset == '0)
    else $error("nonzero offset on unmapped, io or overlay result");

  a_dsp_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && region == padr_pkg::RG_DSPWRAM |-> offset[26:19] == '0)
    else $error("DSP WRAM offset beyond 512KB");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) ##1 in_ready ##1 in_ready |=> out_valid)
    else $error("accepted item did not reach the output in three cycles");
`endif

endmodule

`default_nettype wire

FILE: test/physical_address_region_decoder_core_test.sv
`timescale 1ns / 1ps

module physical_address_region_decoder_core_test;
  import padr_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int PhaseItems = 50;
  localparam int RandPhases = 8;

  localparam bit ACC_READ  = 1'b0;
  localparam bit ACC_WRITE = 1'b1;
  localparam bit REQ_ARM11 = 1'b0;
  localparam bit REQ_ARM9  = 1'b1;

  // indexes past the last register; writes there must be dropped
  localparam logic [2:0] CFG_SPARE6 = 3'd6;
  localparam logic [2:0] CFG_SPARE7 = 3'd7;

  typedef struct {
    region_t     region;
    logic [26:0] offset;
  } decode_t;

  class decode_checker;
    decode_t     pending_decodes[$];
    int          errors = 0;
    logic [63:0] code_map = '0;
    logic [63:0] data_map = '0;
    bit          ram9_ext = 0;
    bit          xvram_en = 0;
    bit          xfcram_en = 0;
    bit          ovl_en = 0;

    function void apply_write(logic [2:0] idx, logic [63:0] data);
      case (idx)
        CFG_CODE_MAP:  code_map = data;
        CFG_DATA_MAP:  data_map = data;
        CFG_ARM9_EXT:  ram9_ext = data[0];
        CFG_EXT_VRAM:  xvram_en = data[0];
        CFG_FCRAM_EXT: xfcram_en = data[0];
        CFG_BOOT_OVL:  ovl_en = data[0];
        default: ;
      endcase
    endfunction

    // lowest enabled block claiming the 32KB slot, -1 if none
    function int first_block(logic [63:0] map, logic [2:0] slot);
      for (int i = 0; i < DspBlocks; i++)
        if (map[8*i+7] && map[8*i+2 +: 3] == slot) return i;
      return -1;
    endfunction

    function void decode_region(logic [31:0] a, bit arm9, bit wr,
                                output region_t rg, output logic [26:0] off);
      logic [31:0] ram9_end;
      logic [31:0] t;
      int          blk;
      bit          hit;
      ram9_end = ram9_ext ? 32'h0818_0000 : 32'h0810_0000;
      hit = 1;
      rg = RG_UNMAPPED;
      off = '0;
      if (a >= 32'h1FF0_0000 && a < 32'h1FF8_0000) begin
        if (a < 32'h1FF4_0000) begin
          blk = first_block(code_map, a[17:15]);
          t = blk;
          t = (t << 15) | (a & 32'h0000_7FFF);
        end else begin
          blk = first_block(data_map, a[17:15]);
          t = blk;
          t = (t << 15) | (a & 32'h0004_7FFF);
        end
        hit = (blk >= 0);
        rg = RG_DSPWRAM;
        off = t[26:0];
      end else if (arm9 && a >= 32'h0800_0000 && a < ram9_end) begin
        rg = RG_ARM9RAM; off = a[20:0];
      end else if (a >= 32'h1800_0000 && a < 32'h1860_0000) begin
        rg = RG_VRAM; off = a[22:0];
      end else if (!arm9 && xvram_en && a >= 32'h1F00_0000 && a < 32'h1F40_0000) begin
        rg = RG_EXTVRAM; off = a[21:0];
      end else if (a >= 32'h1FF8_0000 && a < 32'h2000_0000) begin
        rg = RG_AXIWRAM; off = a[18:0];
      end else if (a >= 32'h2000_0000 && a < 32'h2800_0000) begin
        rg = RG_FCRAM; off = a[26:0];
      end else if (xfcram_en && a >= 32'h2800_0000 && a < 32'h3000_0000) begin
        rg = RG_EXTFCRAM; off = a[26:0];
      end else if (!wr) begin
        if (!arm9 && (a < 32'h0002_0000 || a >= 32'hFFFF_0000) &&
            (a[15:12] != 4'h0 || !ovl_en)) begin
          rg = RG_ROM11; off = a[15:0];
        end else if (arm9 && a >= 32'hFFFF_0000) begin
          rg = RG_ROM9; off = a[15:0];
        end else begin
          hit = 0;
        end
      end else if (!arm9 && a >= 32'hFFFF_E000) begin
        rg = RG_ROM11; off = a[15:0];
      end else begin
        hit = 0;
      end
      if (!hit) begin
        off = '0;
        if (a >= 32'h1000_0000 && a < 32'h1800_0000)
          rg = RG_IO;
        else if (!wr && !arm9 && (a < 32'h0002_0000 || a >= 32'hFFFF_0000))
          rg = RG_OVERLAY;
        else
          rg = RG_UNMAPPED;
      end
    endfunction

    function void note_access(logic [31:0] a, bit arm9, bit wr);
      decode_t d;
      decode_region(a, arm9, wr, d.region, d.offset);
      pending_decodes.push_back(d);
    endfunction

    function void check_decode(logic [3:0] rg, logic [26:0] off);
      decode_t d;
      if (pending_decodes.size() == 0) begin
        errors++;
        $error("result with no access pending: region %0d offset 0x%0h", rg, off);
        return;
      end
      d = pending_decodes.pop_front();
      if (rg !== d.region) begin
        errors++;
        $error("region: expected %0d, actual %0d", d.region, rg);
      end
      if (off !== d.offset) begin
        errors++;
        $error("offset: expected 0x%0h, actual 0x%0h", d.offset, off);
      end
    endfunction

    function int pending();
      return pending_decodes.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] address;
  logic        requester_arm9;
  logic        func;
  logic        out_valid;
  logic        out_ready;
  logic [3:0]  region;
  logic [26:0] offset;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  decode_checker book = new();
  int cycles = 0;
  int tx_calm = 0;
  int rx_calm = 0;

  physical_address_region_decoder_core uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .address        (address),
    .requester_arm9 (requester_arm9),
    .func           (func),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .region         (region),
    .offset         (offset),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // idle cycles before the next item; runs of zero now and then
  function automatic int draw_wait(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) calm_left = $urandom_range(10, 30);
    return $urandom_range(0, 12);
  endfunction

  function automatic logic [31:0] pick_address();
    logic [31:0] edges[18];
    logic [31:0] a;
    edges = '{32'h0000_0000, 32'h0002_0000, 32'h0800_0000, 32'h0810_0000,
              32'h0818_0000, 32'h1000_0000, 32'h1800_0000, 32'h1860_0000,
              32'h1F00_0000, 32'h1F40_0000, 32'h1FF0_0000, 32'h1FF4_0000,
              32'h1FF8_0000, 32'h2000_0000, 32'h2800_0000, 32'h3000_0000,
              32'hFFFF_0000, 32'hFFFF_E000};
    case ($urandom_range(0, 10))
      0: a = $urandom;
      1: a = 32'h1FF0_0000 | $urandom_range(0, 32'h7FFFF);
      2: a = 32'h0800_0000 + $urandom_range(0, 32'h1FFFFF);
      3: a = ($urandom_range(0, 1) ? 32'h1800_0000 : 32'h1F00_0000) +
             $urandom_range(0, 32'h7FFFFF);
      4: a = 32'h1FF8_0000 | $urandom_range(0, 32'h7FFFF);
      5: a = 32'h2000_0000 | ($urandom & 32'h0FFF_FFFF);
      6: a = 32'h1000_0000 | ($urandom & 32'h07FF_FFFF);
      7: a = $urandom_range(0, 32'h3FFFF);
      8: a = 32'hFFFF_0000 | $urandom_range(0, 32'hFFFF);
      9: a = 32'h1FF0_0000 | $urandom_range(0, 32'h7FFFF);
      default: a = edges[$urandom_range(0, 17)] + $urandom_range(0, 3) - 2;
    endcase
    return a;
  endfunction

  // leaves at a falling edge with valid still high; the next call or
  // wait_idle decides what it becomes
  task automatic send_access(logic [31:0] a, bit arm9, bit wr);
    int gap;
    gap = draw_wait(tx_calm);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    address = a;
    requester_arm9 = arm9;
    func = wr;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    book.note_access(a, arm9, wr);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] data);
    cfg_index = idx;
    cfg_data = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    book.apply_write(idx, data);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (book.pending() != 0) @(negedge clk);
    repeat (5) @(negedge clk);
  endtask

  task automatic run_directed();
    send_access(32'h0000_0000, REQ_ARM11, ACC_READ);
    send_access(32'h0000_0000, REQ_ARM11, ACC_WRITE);
    send_access(32'h0001_F000, REQ_ARM9,  ACC_READ);
    send_access(32'h0002_0000, REQ_ARM11, ACC_READ);
    send_access(32'h0800_0000, REQ_ARM9,  ACC_WRITE);
    send_access(32'h080F_FFFF, REQ_ARM9,  ACC_READ);
    send_access(32'h0810_0000, REQ_ARM9,  ACC_READ);
    send_access(32'h0817_FFFF, REQ_ARM11, ACC_READ);
    send_access(32'h1000_0000, REQ_ARM11, ACC_WRITE);
    send_access(32'h17FF_FFFF, REQ_ARM9,  ACC_READ);
    send_access(32'h1800_0000, REQ_ARM11, ACC_READ);
    send_access(32'h185F_FFFF, REQ_ARM9,  ACC_WRITE);
    send_access(32'h1860_0000, REQ_ARM11, ACC_READ);
    send_access(32'h1F00_0000, REQ_ARM11, ACC_READ);
    send_access(32'h1F3F_FFFF, REQ_ARM9,  ACC_READ);
    send_access(32'h1FF0_0000, REQ_ARM11, ACC_READ);
    send_access(32'h1FF7_FFFF, REQ_ARM9,  ACC_WRITE);
    send_access(32'h1FF8_0000, REQ_ARM11, ACC_READ);
    send_access(32'h27FF_FFFF, REQ_ARM9,  ACC_READ);
    send_access(32'h2800_0000, REQ_ARM11, ACC_WRITE);
    send_access(32'h2FFF_FFFF, REQ_ARM9,  ACC_READ);
    send_access(32'hFFFF_0000, REQ_ARM9,  ACC_READ);
    send_access(32'hFFFF_1000, REQ_ARM9,  ACC_WRITE);
    send_access(32'hFFFF_DFFF, REQ_ARM11, ACC_WRITE);
    send_access(32'hFFFF_E000, REQ_ARM11, ACC_WRITE);
    send_access(32'hFFFF_0FFF, REQ_ARM11, ACC_READ);
  endtask

  task automatic write_all(logic [63:0] code, logic [63:0] data, logic [63:0] r9,
                           logic [63:0] xv, logic [63:0] xf, logic [63:0] ov);
    write_reg(CFG_CODE_MAP, code);
    write_reg(CFG_DATA_MAP, data);
    write_reg(CFG_ARM9_EXT, r9);
    write_reg(CFG_EXT_VRAM, xv);
    write_reg(CFG_FCRAM_EXT, xf);
    write_reg(CFG_BOOT_OVL, ov);
  endtask

  // receive side
  initial begin
    int stall;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = draw_wait(rx_calm);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      book.check_decode(region, offset);
      @(negedge clk);
    end
  end

  initial begin
    logic [63:0] cmap;
    logic [63:0] dmap;
    rst = 1'b1;
    in_valid = 1'b0;
    address = '0;
    requester_arm9 = 1'b0;
    func = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // registers at their reset values: every DSP slot unclaimed
    run_directed();
    wait_idle();

    // every block enabled, slots reversed so block 7 claims slot 0;
    // all data blocks on slot 7 so the lowest one must win
    write_all(64'h8084_888C_9094_989C, '1, 64'd1, 64'd1, 64'd1, 64'd1);
    cfg_valid = 1'b0;
    run_directed();

    for (int p = 0; p < RandPhases; p++) begin
      wait_idle();
      case (p)
        0: begin
          write_all('0, '0, '0, '0, '0, '0);
          write_reg(CFG_SPARE6, {$urandom, $urandom});
          write_reg(CFG_SPARE7, '1);
        end
        1: write_all('1, '1, '1, '1, '1, '1);
        default: begin
          cmap = {$urandom, $urandom};
          dmap = {$urandom, $urandom};
          if ($urandom_range(0, 1)) cmap = cmap | 64'h8080_8080_8080_8080;
          if ($urandom_range(0, 1)) dmap = dmap | 64'h8080_8080_8080_8080;
          write_all(cmap, dmap, {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom});
          if ($urandom_range(0, 2) == 0) write_reg(CFG_SPARE6, {$urandom, $urandom});
        end
      endcase
      cfg_valid = 1'b0;
      repeat (PhaseItems) send_access(pick_address(), $urandom_range(0, 1),
                                      $urandom_range(0, 1));
    end

    in_valid = 1'b0;
    while (book.pending() != 0) @(negedge clk);
    repeat (10) @(posedge clk);
    if (book.errors == 0 && book.pending() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
